FILE: rtl/core/lprp_pkg.sv
// Package for the length-prefixed record parser.
// Holds phase codes, result and state types, and result constructors.
// No dependencies.
package lprp_pkg;

	localparam int FIELDS_PER_RECORD = 5;
	localparam int HEADER_BYTES      = 4;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN_LO = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;
	localparam logic [2:0] PH_DROP   = 3'd5;

	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	localparam logic [1:0] ERR_SHORT   = 2'd0;
	localparam logic [1:0] ERR_RECORDS = 2'd1;
	localparam logic [1:0] ERR_FIELD   = 2'd2;
	localparam logic [1:0] ERR_TRUNC   = 2'd3;

	localparam logic REG_MAX_RECORDS     = 1'b0;
	localparam logic REG_MAX_FIELD_BYTES = 1'b1;

	localparam logic [15:0] MAX_RECORDS_RESET     = 16'd256;
	localparam logic [16:0] MAX_FIELD_BYTES_RESET = 17'd256;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  field_byte;
		logic [15:0] record_index;
		logic [2:0]  field_index;
		logic        field_end;
		logic [1:0]  error_code;
		logic        last_of_item;
	} result_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  prefix_count;
		logic [31:0] record_count;
		logic [15:0] current_record;
		logic [2:0]  current_field;
		logic [15:0] bytes_left;
	} parser_state_t;

	localparam parser_state_t STATE_REARM = '{
		phase: PH_HEADER,
		prefix_count: 2'd0,
		record_count: 32'd0,
		current_record: 16'd0,
		current_field: 3'd0,
		bytes_left: 16'd0
	};

	localparam result_t RESULT_NONE = '0;

	function automatic result_t make_error(input logic [1:0] code);
		result_t r;
		r = RESULT_NONE;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t make_complete();
		result_t r;
		r = RESULT_NONE;
		r.kind = KIND_COMPLETE;
		return r;
	endfunction

	function automatic result_t make_field(input logic [1:0] kind, input logic [7:0] data,
			input logic [15:0] rec, input logic [2:0] fld, input logic fend);
		result_t r;
		r = RESULT_NONE;
		r.kind = kind;
		r.field_byte = data;
		r.record_index = rec;
		r.field_index = fld;
		r.field_end = fend;
		return r;
	endfunction

endpackage

FILE: rtl/core/length_prefixed_record_parser.sv
// Length-prefixed record parser, top level.
// Input channel: stream_byte with end_of_data, handshake stream_valid / stream_stall.
// Output channel: one result per transaction (kind, field_byte, record_index,
// field_index, field_end, error_code, last_of_item), handshake result_valid /
// result_stall. Configuration: cfg_write, cfg_index, cfg_data; index 0 sets the
// record limit, index 1 the field length limit; write only while idle.
// Latency: results of a byte enter the result queue at the edge that takes the
// byte, so with the queue empty the first shows on result_valid in the next cycle.
// Throughput: one byte per cycle; a byte gives zero, one or two results and
// the queue drains one per cycle, so the rate is set by the queue's read port.
// stream_stall rises while the queue cannot take two more results, i.e. when
// the receiver holds result_stall high long enough to fill it.
// Reset: parser rearms for a new stream header, queue empties, limits return
// to 256. After the byte with end_of_data the parser rearms by itself.
// Depends on lprp_pkg, lprp_step, lprp_outq.
module length_prefixed_record_parser
	import lprp_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stream_valid,
	output logic        stream_stall,
	input  logic [7:0]  stream_byte,
	input  logic        end_of_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  field_byte,
	output logic [15:0] record_index,
	output logic [2:0]  field_index,
	output logic        field_end,
	output logic [1:0]  error_code,
	output logic        last_of_item,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	parser_state_t state_q;
	parser_state_t state_next;
	logic [15:0]   max_records_q;
	logic [16:0]   max_field_bytes_q;
	result_t       res0;
	result_t       res1;
	result_t       head;
	logic [1:0]    res_count;
	logic          accept;
	logic          queue_full;

	assign accept = stream_valid && !stream_stall;
	assign stream_stall = queue_full;

	lprp_step u_step (
		.cur             (state_q),
		.stream_byte     (stream_byte),
		.end_of_data     (end_of_data),
		.max_records     (max_records_q),
		.max_field_bytes (max_field_bytes_q),
		.nxt             (state_next),
		.res0            (res0),
		.res1            (res1),
		.res_count       (res_count)
	);

	lprp_outq #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (accept && res_count != 2'd0),
		.push1     (accept && res_count == 2'd2),
		.res0      (res0),
		.res1      (res1),
		.full      (queue_full),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (head)
	);

	assign kind         = head.kind;
	assign field_byte   = head.field_byte;
	assign record_index = head.record_index;
	assign field_index  = head.field_index;
	assign field_end    = head.field_end;
	assign error_code   = head.error_code;
	assign last_of_item = head.last_of_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_REARM;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q <= MAX_RECORDS_RESET;
			max_field_bytes_q <= MAX_FIELD_BYTES_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_RECORDS: max_records_q <= cfg_data[15:0];
				REG_MAX_FIELD_BYTES: max_field_bytes_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/lprp_step.sv
// Per-byte parse logic: next state and up to two results for one byte.
// Depends on lprp_pkg.
module lprp_step
	import lprp_pkg::*;
(
	input  parser_state_t cur,
	input  logic [7:0]    stream_byte,
	input  logic          end_of_data,
	input  logic [15:0]   max_records,
	input  logic [16:0]   max_field_bytes,
	output parser_state_t nxt,
	output result_t       res0,
	output result_t       res1,
	output logic [1:0]    res_count
);

	always_comb begin
		logic [31:0]   count_acc;
		logic [15:0]   len;
		logic [15:0]   left_dec;
		logic [15:0]   rec_inc;
		logic [2:0]    fld_inc;
		logic          adv;
		result_t       a;
		result_t       b;
		result_t       c;
		logic          a_v;
		logic          b_v;
		logic          c_v;

		nxt = cur;
		a = RESULT_NONE;
		b = RESULT_NONE;
		c = RESULT_NONE;
		a_v = 1'b0;
		b_v = 1'b0;
		c_v = 1'b0;
		adv = 1'b0;
		count_acc = cur.record_count | ({24'd0, stream_byte} << {cur.prefix_count, 3'b000});
		len = {stream_byte, cur.bytes_left[7:0]};
		left_dec = cur.bytes_left - 16'd1;
		rec_inc = cur.current_record + 16'd1;
		fld_inc = cur.current_field + 3'd1;

		unique case (cur.phase)
			PH_HEADER: begin
				nxt.record_count = count_acc;
				if (cur.prefix_count == 2'(HEADER_BYTES - 1)) begin
					nxt.prefix_count = 2'd0;
					if (count_acc > {16'd0, max_records}) begin
						a = make_error(ERR_RECORDS);
						a_v = 1'b1;
						nxt.phase = PH_DROP;
					end else if (count_acc == 32'd0) begin
						a = make_complete();
						a_v = 1'b1;
						nxt.phase = PH_DONE;
					end else begin
						nxt.phase = PH_LEN_LO;
					end
				end else begin
					nxt.prefix_count = cur.prefix_count + 2'd1;
				end
			end
			PH_LEN_LO: begin
				nxt.bytes_left = {8'd0, stream_byte};
				nxt.phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if ({1'b0, len} >= max_field_bytes) begin
					a = make_error(ERR_FIELD);
					a_v = 1'b1;
					nxt.phase = PH_DROP;
				end else if (len == 16'd0) begin
					a = make_field(KIND_EMPTY, 8'd0, cur.current_record, cur.current_field, 1'b0);
					a_v = 1'b1;
					nxt.bytes_left = 16'd0;
					adv = 1'b1;
				end else begin
					nxt.bytes_left = len;
					nxt.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				nxt.bytes_left = left_dec;
				a = make_field(KIND_BYTE, stream_byte, cur.current_record, cur.current_field,
					left_dec == 16'd0);
				a_v = 1'b1;
				adv = (left_dec == 16'd0);
			end
			PH_DONE, PH_DROP: begin
			end
			default: begin
			end
		endcase

		// advance to the next field, and to the next record after the last field
		if (adv) begin
			if (fld_inc >= 3'(FIELDS_PER_RECORD)) begin
				nxt.current_field = 3'd0;
				nxt.current_record = rec_inc;
				if ({16'd0, rec_inc} >= cur.record_count) begin
					b = make_complete();
					b_v = 1'b1;
					nxt.phase = PH_DONE;
				end else begin
					nxt.phase = PH_LEN_LO;
				end
			end else begin
				nxt.current_field = fld_inc;
				nxt.phase = PH_LEN_LO;
			end
		end

		if (end_of_data) begin
			if (nxt.phase == PH_HEADER) begin
				c = make_error(ERR_SHORT);
				c_v = 1'b1;
			end else if (nxt.phase == PH_LEN_LO || nxt.phase == PH_LEN_HI
					|| nxt.phase == PH_DATA) begin
				c = make_error(ERR_TRUNC);
				c_v = 1'b1;
			end
			nxt = STATE_REARM;
		end

		// pack at most two results in order
		res0 = RESULT_NONE;
		res1 = RESULT_NONE;
		if (a_v) begin
			res0 = a;
			res1 = b_v ? b : c;
		end else if (b_v) begin
			res0 = b;
			res1 = c;
		end else begin
			res0 = c;
		end
		res_count = 2'(a_v) + 2'(b_v) + 2'(c_v);
		res0.last_of_item = (res_count == 2'd1);
		res1.last_of_item = 1'b1;
	end

endmodule

FILE: rtl/core/lprp_outq.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while out_stall is low.
// Depends on lprp_pkg.
module lprp_outq
	import lprp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push0,
	input  logic    push1,
	input  result_t res0,
	input  result_t res1,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_ptr_inc;
	logic [PTR_W-1:0]   wr_ptr_inc2;
	logic [PTR_W-1:0]   rd_ptr_inc;
	logic               pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ptr_inc  = ptr_next(wr_ptr_q);
	assign wr_ptr_inc2 = ptr_next(wr_ptr_inc);
	assign rd_ptr_inc  = ptr_next(rd_ptr_q);
	assign out_valid   = (count_q != '0);
	assign out_res     = entry_q[rd_ptr_q];
	assign pop         = out_valid && !out_stall;
	assign full        = (count_q > CNT_W'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push1) begin
				wr_ptr_q <= wr_ptr_inc2;
			end else if (push0) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			count_q <= count_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			entry_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			entry_q[wr_ptr_inc] <= res1;
		end
	end

endmodule

FILE: rtl/core/lprp_checker.sv
// Port-level checks on the record parser's result channel, and their bind.
// Depends on lprp_pkg and the top level length_prefixed_record_parser.
module lprp_checker
	import lprp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  kind,
	input logic [7:0]  field_byte,
	input logic [15:0] record_index,
	input logic [2:0]  field_index,
	input logic        field_end,
	input logic [1:0]  error_code,
	input logic        last_of_item
);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind)
			&& $stable(field_byte) && $stable(record_index) && $stable(field_index)
			&& $stable(field_end) && $stable(error_code) && $stable(last_of_item))
		else $error("stalled result transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != KIND_BYTE |-> field_byte == 8'd0 && field_end == 1'b0)
		else $error("payload byte or field end on a non-byte result");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_COMPLETE || kind == KIND_ERROR)
			|-> record_index == 16'd0 && field_index == 3'd0 && last_of_item)
		else $error("completion or error result carries position or is not last");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> field_index < 3'(FIELDS_PER_RECORD)
			&& (kind == KIND_ERROR || error_code == 2'd0))
		else $error("field index out of range or stray error code");

endmodule

bind length_prefixed_record_parser lprp_checker u_lprp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.field_byte   (field_byte),
	.record_index (record_index),
	.field_index  (field_index),
	.field_end    (field_end),
	.error_code   (error_code),
	.last_of_item (last_of_item)
);

FILE: test/tb_length_prefixed_record_parser.sv
// Self-checking testbench for length_prefixed_record_parser: streams of
// length-prefixed records under several limit settings, checked per field
// against a built-in parser model. Depends on lprp_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_length_prefixed_record_parser;
	import lprp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_BYTES    = 155;
	localparam int NUM_PHASES     = 9;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        stream_valid = 1'b0;
	logic        stream_stall;
	logic [7:0]  stream_byte = '0;
	logic        end_of_data = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  field_byte;
	logic [15:0] record_index;
	logic [2:0]  field_index;
	logic        field_end;
	logic [1:0]  error_code;
	logic        last_of_item;
	logic        cfg_write = 1'b0;
	logic        cfg_index = REG_MAX_RECORDS;
	logic [16:0] cfg_data = '0;

	length_prefixed_record_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_byte  (stream_byte),
		.end_of_data  (end_of_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.field_byte   (field_byte),
		.record_index (record_index),
		.field_index  (field_index),
		.field_end    (field_end),
		.error_code   (error_code),
		.last_of_item (last_of_item),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stream_item_t  byte_queue[$];
	result_t       due_results[$];
	result_t       item_out[$];
	parser_state_t st = '0;
	logic [15:0]   lim_records = MAX_RECORDS_RESET;
	logic [16:0]   lim_field = MAX_FIELD_BYTES_RESET;

	bit          calm = 1'b0;
	int          mismatches = 0;
	int unsigned bytes_queued = 0;
	int unsigned bytes_taken = 0;
	int unsigned results_checked = 0;
	int unsigned errors_seen = 0;
	int unsigned completions_seen = 0;
	int unsigned limit_writes = 0;
	int unsigned idle_left = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	stream_item_t next_item;
	result_t      got;
	result_t      want;

	function automatic void emit(input logic [1:0] k, input logic [7:0] data,
			input logic [15:0] rec, input logic [2:0] fld, input logic fend,
			input logic [1:0] code);
		result_t r;
		r = '0;
		r.kind = k;
		r.field_byte = data;
		r.record_index = rec;
		r.field_index = fld;
		r.field_end = fend;
		r.error_code = code;
		item_out.push_back(r);
	endfunction

	function automatic void raise_error(input logic [1:0] code);
		emit(KIND_ERROR, 8'd0, 16'd0, 3'd0, 1'b0, code);
		st.phase = PH_DROP;
	endfunction

	function automatic void next_field();
		st.current_field++;
		if (st.current_field >= 3'(FIELDS_PER_RECORD)) begin
			st.current_field = 3'd0;
			st.current_record++;
			if (32'(st.current_record) >= st.record_count) begin
				emit(KIND_COMPLETE, 8'd0, 16'd0, 3'd0, 1'b0, ERR_SHORT);
				st.phase = PH_DONE;
				return;
			end
		end
		st.phase = PH_LEN_LO;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic eod);
		logic [16:0] len;
		logic        fend;
		item_out.delete();
		case (st.phase)
			PH_HEADER: begin
				st.record_count |= 32'(b) << (8 * st.prefix_count);
				if (st.prefix_count == 2'd3) begin
					st.prefix_count = 2'd0;
					if (st.record_count > 32'(lim_records)) begin
						raise_error(ERR_RECORDS);
					end else if (st.record_count == 32'd0) begin
						emit(KIND_COMPLETE, 8'd0, 16'd0, 3'd0, 1'b0, ERR_SHORT);
						st.phase = PH_DONE;
					end else begin
						st.phase = PH_LEN_LO;
					end
				end else begin
					st.prefix_count++;
				end
			end
			PH_LEN_LO: begin
				st.bytes_left = {8'd0, b};
				st.phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len = {1'b0, b, st.bytes_left[7:0]};
				if (len >= lim_field) begin
					raise_error(ERR_FIELD);
				end else if (len == 17'd0) begin
					emit(KIND_EMPTY, 8'd0, st.current_record, st.current_field, 1'b0, ERR_SHORT);
					st.bytes_left = 16'd0;
					next_field();
				end else begin
					st.bytes_left = len[15:0];
					st.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				st.bytes_left--;
				fend = (st.bytes_left == 16'd0);
				emit(KIND_BYTE, b, st.current_record, st.current_field, fend, ERR_SHORT);
				if (fend)
					next_field();
			end
			default: ;
		endcase
		if (eod) begin
			if (st.phase == PH_HEADER)
				raise_error(ERR_SHORT);
			else if (st.phase == PH_LEN_LO || st.phase == PH_LEN_HI || st.phase == PH_DATA)
				raise_error(ERR_TRUNC);
			st = '0;
			st.phase = PH_HEADER;
		end
		if (item_out.size() != 0)
			item_out[item_out.size() - 1].last_of_item = 1'b1;
		foreach (item_out[i])
			due_results.push_back(item_out[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned g, input int unsigned w);
		if (g != w)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, g, w));
	endtask

	always @(posedge clk) begin
		if (cfg_write) begin
			if (cfg_index == REG_MAX_RECORDS)
				lim_records <= cfg_data[15:0];
			else
				lim_field <= cfg_data;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (stream_valid && !stream_stall) begin
				parse_byte(stream_byte, end_of_data);
				bytes_taken++;
			end
			if (!stream_valid || !stream_stall) begin
				if (idle_left != 0) begin
					idle_left--;
					stream_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					idle_left = $urandom_range(1, 10) - 1;
					stream_valid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					next_item = byte_queue.pop_front();
					stream_byte <= next_item.data;
					end_of_data <= next_item.last;
					stream_valid <= 1'b1;
				end else begin
					stream_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got = {kind, field_byte, record_index, field_index, field_end, error_code,
					last_of_item};
				results_checked++;
				if (got.kind == KIND_ERROR)
					errors_seen++;
				if (got.kind == KIND_COMPLETE)
					completions_seen++;
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result 0x%0h", got));
				end else begin
					want = due_results.pop_front();
					check_field("kind", got.kind, want.kind);
					check_field("field_byte", got.field_byte, want.field_byte);
					check_field("record_index", got.record_index, want.record_index);
					check_field("field_index", got.field_index, want.field_index);
					check_field("field_end", got.field_end, want.field_end);
					check_field("error_code", got.error_code, want.error_code);
					check_field("last_of_item", got.last_of_item, want.last_of_item);
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((stream_valid && !stream_stall) || (result_valid === 1'b1 && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, due_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_stream(input logic [7:0] s[$]);
		stream_item_t it;
		foreach (s[i]) begin
			it.data = s[i];
			it.last = (i == s.size() - 1);
			byte_queue.push_back(it);
			bytes_queued++;
		end
	endtask

	task automatic write_limit(input logic idx, input logic [16:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		limit_writes++;
	endtask

	task automatic wait_idle();
		while (byte_queue.size() != 0 || stream_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int unsigned pick_length();
		int unsigned top;
		int unsigned cap;
		int unsigned r;
		top = (lim_field == 17'd0) ? 0 : int'(lim_field) - 1;
		cap = (top > 6) ? 6 : top;
		r = $urandom_range(0, 15);
		if (r < 3)
			return 0;
		if (r == 15 && top <= 48)
			return top;
		if (r == 15)
			return $urandom_range(7, 48);
		if (r == 14 && top >= 300 && $urandom_range(0, 3) == 0)
			return $urandom_range(256, 300);
		return $urandom_range(0, cap);
	endfunction

	// modes: well-formed, truncated, field too long, too many records,
	// short header, zero records
	task automatic queue_random_stream();
		logic [7:0]  s[$];
		logic [31:0] count;
		int unsigned mode;
		int unsigned nfields;
		int unsigned bad_at;
		int unsigned len;
		int unsigned cut;
		bit          too_long;
		mode = $urandom_range(0, 19);
		if (mode == 17)
			count = $urandom_range(0, 1) ? 32'(lim_records) + 32'd1 : ($urandom | 32'h0001_0000);
		else if (mode == 19 || lim_records == 16'd0)
			count = 32'd0;
		else
			count = $urandom_range(1, (lim_records < 16'd3) ? int'(lim_records) : 3);
		for (int i = 0; i < 4; i++)
			s.push_back(count[8 * i +: 8]);
		if (mode != 17 && mode != 18) begin
			nfields = count * FIELDS_PER_RECORD;
			bad_at = (nfields == 0) ? 0 : $urandom_range(0, nfields - 1);
			for (int f = 0; f < nfields; f++) begin
				too_long = (mode == 15 || mode == 16) && f == bad_at && lim_field <= 17'd65535;
				len = too_long ? $urandom_range(int'(lim_field), 65535) : pick_length();
				s.push_back(len[7:0]);
				s.push_back(len[15:8]);
				if (too_long)
					break;
				repeat (len) s.push_back(8'($urandom));
			end
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) s.push_back(8'($urandom));
		if (mode == 18) begin
			cut = $urandom_range(1, 3);
			s = s[0:cut - 1];
		end else if (mode >= 12 && mode <= 14 && s.size() > 5) begin
			cut = $urandom_range(4, s.size() - 1);
			s = s[0:cut - 1];
		end
		send_stream(s);
	endtask

	initial begin
		logic [7:0]  s[$];
		logic [15:0] rec_set[NUM_PHASES];
		logic [16:0] fld_set[NUM_PHASES];
		int unsigned phase_start;
		rec_set = '{16'd65535, 16'd0, 16'd1, 16'd3, 16'd2, 16'(0), 16'd3, 16'(0), 16'd256};
		fld_set = '{17'd65536, 17'd256, 17'd1, 17'd0, 17'd8, 17'd1, 17'd40, 17'd1, 17'd256};
		rec_set[5] = $urandom_range(0, 65535);
		fld_set[5] = $urandom_range(1, 65536);
		rec_set[7] = $urandom_range(0, 65535);
		fld_set[7] = $urandom_range(1, 65536);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		s = '{8'h00};
		send_stream(s);
		s = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_stream(s);
		s = '{8'h01, 8'h01, 8'h00, 8'h00, 8'hAA};
		send_stream(s);
		s = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h01};
		send_stream(s);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_limit(REG_MAX_RECORDS, 17'(rec_set[p]));
			write_limit(REG_MAX_FIELD_BYTES, fld_set[p]);
			@(negedge clk);
			calm = (p == NUM_PHASES - 1);
			if (p == 0) begin
				s = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
				send_stream(s);
				s = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h11, 8'h22, 8'h33};
				send_stream(s);
			end
			phase_start = bytes_queued;
			while (bytes_queued - phase_start < PHASE_BYTES)
				queue_random_stream();
			wait_idle();
		end

		$display("covered %0d stream bytes and %0d limit writes over %0d settings", bytes_taken,
			limit_writes, NUM_PHASES);
		$display("checked %0d results: %0d errors, %0d completions", results_checked,
			errors_seen, completions_seen);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never seen", mismatches, due_results.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
